### rtl/approx_substring_matcher_top_assert.svh
// Assertion macros used by the approximate substring matcher checker
`ifndef APPROX_SUBSTRING_MATCHER_TOP_ASSERT_SVH
`define APPROX_SUBSTRING_MATCHER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("asm: same-cycle check violated");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("asm: next-cycle check violated");

`endif

### rtl/asm_pkg.sv
// Types and constants of the approximate substring matcher
package asm_pkg;

  localparam int KIND_W = 2;
  localparam int SYM_W  = 8;
  localparam int IDX_W  = 6;
  localparam int K_W    = 6;
  localparam int LEN_W  = 7;
  localparam int POS_W  = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;
    logic [IDX_W-1:0]  pattern_index;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] match_end;
  } out_item_t;

endpackage

### rtl/asm_stream_if.sv
// Valid/ready item channel with a typed payload
interface asm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/asm_cell.sv
// One row cell: pattern byte, column cost and the wavefront hand-over
module asm_cell
  import asm_pkg::*;
#(
  parameter int CW  = 7,
  parameter int ROW = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic             load_en_i,
  input  logic [SYM_W-1:0] load_sym_i,
  input  logic [SYM_W-1:0] sym_i,
  input  logic [K_W-1:0]   thresh_i,
  input  logic             tok_i,
  input  logic [CW-1:0]    cur_i,
  input  logic [CW-1:0]    diag_i,
  output logic             tok_o,
  output logic [CW-1:0]    cur_o,
  output logic [CW-1:0]    diag_o,
  output logic             good_o
);

  localparam int KW = (CW > K_W) ? CW : K_W;
  localparam logic [CW-1:0] RESET_COST = CW'(ROW + 1);

  logic [SYM_W-1:0] pat_q;
  logic [CW-1:0]    cost_q;
  logic             tok_q;
  logic [CW-1:0]    cur_q;
  logic [CW-1:0]    diag_q;
  logic [CW-1:0]    min_v;
  logic [CW-1:0]    cur_d;

  always_comb begin
    min_v = diag_i;
    if (cur_i < min_v) begin
      min_v = cur_i;
    end
    if (cost_q < min_v) begin
      min_v = cost_q;
    end
    cur_d  = (pat_q == sym_i) ? diag_i : min_v + CW'(1);
    good_o = tok_i && (KW'(cur_d) <= KW'(thresh_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q <= RESET_COST;
      tok_q  <= 1'b0;
    end else begin
      tok_q <= tok_i;
      if (restart_i) begin
        cost_q <= RESET_COST;
      end else if (tok_i) begin
        cost_q <= cur_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      pat_q <= load_sym_i;
    end
    cur_q  <= cur_d;
    diag_q <= cost_q;
  end

  assign tok_o  = tok_q;
  assign cur_o  = cur_q;
  assign diag_o = diag_q;

endmodule

### rtl/approx_substring_matcher_top.sv
// Top level of the approximate substring matcher: control and cell row
// Load, restart and unused items leave the control idle; ready stays high.
// A text item walks the cost wavefront along the first min(active rows, length)
// cells, one cell per cycle; then S_FIN settles the cut-off, waiting there while a
// new match meets an untaken result. A match result is registered and shown the cycle after that settling step.
// Reset (async, active low) clears control, costs to row + 1, position to 0.
module approx_substring_matcher_top
  import asm_pkg::*;
#(
  parameter int MAX_PATTERN = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  asm_stream_if.sink           in_i,
  asm_stream_if.source         out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEN_W-1:0]     cfg_data_i
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int RW = $clog2(MAX_PATTERN);
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;
  localparam int IW = (RW > IDX_W) ? RW : IDX_W;
  localparam int SW = (CW > K_W + 1) ? CW : K_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [K_W-1:0]   thresh_q;
  logic [LEN_W-1:0] len_q;
  logic [CW-1:0]    active_q, active_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [SYM_W-1:0] sym_q;
  logic [CW-1:0]    last_q, last_d;
  logic [RW-1:0]    row_q, row_d;
  logic [CW-1:0]    good_last_q, good_last_d;
  logic             start_q, start_d;
  logic             out_valid_q, out_valid_d;
  logic [POS_W-1:0] out_data_q;

  logic [CW-1:0]    len_eff;
  logic [CW-1:0]    cap_last;
  logic [SW-1:0]    k_plus;
  logic [CW-1:0]    restart_active;
  logic [POS_W-1:0] pos_inc;
  logic             in_fire;
  logic             out_fire;
  logic             text_fire;
  logic             restart;
  logic             fin_hit;
  logic             fin_commit;
  logic             any_good;

  logic [MAX_PATTERN-1:0] tok_in;
  logic [CW-1:0]          cur_in  [MAX_PATTERN];
  logic [CW-1:0]          diag_in [MAX_PATTERN];
  logic [MAX_PATTERN-2:0] tok_out;
  logic [CW-1:0]          cur_out  [MAX_PATTERN-1];
  logic [CW-1:0]          diag_out [MAX_PATTERN-1];
  logic [MAX_PATTERN-1:0] good_vec;
  logic [MAX_PATTERN-1:0] load_en;

  always_comb begin
    if (len_q == '0) begin
      len_eff = CW'(1);
    end else if (LW'(len_q) > LW'(MAX_PATTERN)) begin
      len_eff = CW'(MAX_PATTERN);
    end else begin
      len_eff = CW'(len_q);
    end
    cap_last       = (active_q > len_eff) ? len_eff : active_q;
    k_plus         = SW'(thresh_q) + SW'(1);
    restart_active = (k_plus < SW'(len_eff)) ? CW'(k_plus) : len_eff;
    pos_inc        = (&pos_q) ? pos_q : pos_q + POS_W'(1);
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;
  assign text_fire  = in_fire && (in_i.data.kind == KIND_TEXT);
  assign restart    = in_fire && (in_i.data.kind == KIND_RESTART);
  assign any_good   = |good_vec;
  assign fin_hit    = (good_last_q == len_eff);
  assign fin_commit = (state_q == S_FIN) && !(fin_hit && out_valid_q && !out_o.ready);

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    pos_d       = pos_q;
    last_d      = last_q;
    row_d       = row_q;
    good_last_d = good_last_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q && !out_fire;
    case (state_q)
      S_IDLE: begin
        if (text_fire) begin
          last_d      = cap_last;
          row_d       = '0;
          good_last_d = '0;
          start_d     = 1'b1;
          state_d     = S_RUN;
        end else if (restart) begin
          active_d = restart_active;
          pos_d    = '0;
        end
      end
      S_RUN: begin
        if (any_good) begin
          good_last_d = CW'(row_q) + CW'(1);
        end
        if (row_q == RW'(last_q - CW'(1))) begin
          state_d = S_FIN;
        end else begin
          row_d = row_q + RW'(1);
        end
      end
      S_FIN: begin
        if (fin_commit) begin
          active_d = fin_hit ? good_last_q : good_last_q + CW'(1);
          pos_d    = pos_inc;
          if (fin_hit) begin
            out_valid_d = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thresh_q    <= '0;
      len_q       <= LEN_W'(1);
      active_q    <= CW'(1);
      pos_q       <= '0;
      last_q      <= CW'(1);
      row_q       <= '0;
      good_last_q <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      pos_q       <= pos_d;
      last_q      <= last_d;
      row_q       <= row_d;
      good_last_q <= good_last_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD: thresh_q <= cfg_data_i[K_W-1:0];
          CFG_LENGTH:    len_q    <= cfg_data_i;
          default:       len_q    <= len_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_fire) begin
      sym_q <= in_i.data.symbol;
    end
    if (fin_commit && fin_hit) begin
      out_data_q <= pos_inc;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.data.match_end = out_data_q;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    assign load_en[i] = in_fire && (in_i.data.kind == KIND_LOAD)
                        && (IW'(in_i.data.pattern_index) == IW'(i));
    if (i == 0) begin : g_head
      assign tok_in[i]  = start_q;
      assign cur_in[i]  = '0;
      assign diag_in[i] = '0;
    end else begin : g_link
      assign tok_in[i]  = tok_out[i-1] && (CW'(i) < last_q);
      assign cur_in[i]  = cur_out[i-1];
      assign diag_in[i] = diag_out[i-1];
    end
    if (i < MAX_PATTERN - 1) begin : g_mid
      asm_cell #(.CW(CW), .ROW(i)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .restart_i  (restart),
        .load_en_i  (load_en[i]),
        .load_sym_i (in_i.data.symbol),
        .sym_i      (sym_q),
        .thresh_i   (thresh_q),
        .tok_i      (tok_in[i]),
        .cur_i      (cur_in[i]),
        .diag_i     (diag_in[i]),
        .tok_o      (tok_out[i]),
        .cur_o      (cur_out[i]),
        .diag_o     (diag_out[i]),
        .good_o     (good_vec[i])
      );
    end else begin : g_tail
      asm_cell #(.CW(CW), .ROW(i)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .restart_i  (restart),
        .load_en_i  (load_en[i]),
        .load_sym_i (in_i.data.symbol),
        .sym_i      (sym_q),
        .thresh_i   (thresh_q),
        .tok_i      (tok_in[i]),
        .cur_i      (cur_in[i]),
        .diag_i     (diag_in[i]),
        .tok_o      (),
        .cur_o      (),
        .diag_o     (),
        .good_o     (good_vec[i])
      );
    end
  end

endmodule

### rtl/asm_checker.sv
// Port-level checker for the approximate substring matcher and its bind
`include "approx_substring_matcher_top_assert.svh"

module asm_checker
  import asm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [KIND_W-1:0] in_kind_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [POS_W-1:0]  out_match_end_i
);

  `ASM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_match_end_i))
  `ASM_ASSERT_NEXT(a_text_busy, in_valid_i && in_ready_i && (in_kind_i == KIND_TEXT), !in_ready_i)
  `ASM_ASSERT_NOW(a_result_idle, $rose(out_valid_i), in_ready_i)
  `ASM_ASSERT_NOW(a_end_nonzero, out_valid_i, out_match_end_i != '0)

endmodule

bind approx_substring_matcher_top asm_checker u_asm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_kind_i       (in_i.data.kind),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_match_end_i (out_o.data.match_end)
);

### bench/tb_approx_substring_matcher_top.sv
// Testbench of the approximate substring matcher: directed and random items against a predictor
`timescale 1ns / 100ps

module tb_approx_substring_matcher_top;
  import asm_pkg::*;

  localparam int MAX_PAT = 64;
  localparam int DRAIN = MAX_PAT + 8;
  localparam int LONG_HOLD = 400;
  localparam int LIMIT = 500000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  class match_predictor;
    logic [SYM_W-1:0] pattern_img [MAX_PAT];
    logic [LEN_W-1:0] costs [MAX_PAT];
    logic [LEN_W-1:0] active;
    logic [K_W-1:0]   thresh;
    logic [LEN_W-1:0] plen;
    logic [POS_W-1:0] pos;
    out_item_t        ends_q[$];
    int unsigned      errors;

    function new();
      errors = 0;
      thresh = '0;
      plen = LEN_W'(1);
      foreach (pattern_img[i]) pattern_img[i] = '0;
      restart();
    endfunction

    function int unsigned eff_len();
      if (plen == 0) return 1;
      if (plen > MAX_PAT) return MAX_PAT;
      return plen;
    endfunction

    function void restart();
      int unsigned len;
      len = eff_len();
      foreach (costs[i]) costs[i] = LEN_W'(i + 1);
      active = (thresh + 1 > len) ? LEN_W'(len) : LEN_W'(thresh + 1);
      pos = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
      if (idx == CFG_THRESHOLD) thresh = val[K_W-1:0];
      else plen = val;
    endfunction

    function void scan_text(logic [SYM_W-1:0] sym);
      int unsigned len, last, diag, cur, up;
      bit hit;
      out_item_t e;
      len = eff_len();
      last = (active > len) ? len : active;
      diag = 0;
      cur = 0;
      for (int i = 0; i < last; i++) begin
        up = costs[i];
        if (pattern_img[i] == sym) begin
          cur = diag;
        end else begin
          if (diag < cur) cur = diag;
          if (up < cur) cur = up;
          cur++;
        end
        diag = up;
        costs[i] = LEN_W'(cur);
      end
      while (last > 0 && costs[last-1] > thresh) last--;
      hit = (last == len);
      if (!hit) last++;
      active = LEN_W'(last);
      if (pos != '1) pos++;
      if (hit) begin
        e.match_end = pos;
        ends_q = {ends_q, e};
      end
    endfunction

    function void note_item(in_item_t it);
      case (it.kind)
        KIND_LOAD:    pattern_img[it.pattern_index] = it.symbol;
        KIND_RESTART: restart();
        KIND_TEXT:    scan_text(it.symbol);
        default:      ;
      endcase
    endfunction

    function void check_end(out_item_t got);
      out_item_t want;
      if (ends_q.size() == 0) begin
        $display("%0t: match_end %0d arrived with nothing expected", $time, got.match_end);
        errors++;
      end else begin
        want = ends_q.pop_front();
        if (got.match_end !== want.match_end) begin
          $display("%0t: match_end expected %0d, got %0d", $time, want.match_end,
                   got.match_end);
          errors++;
        end
      end
    endfunction

    function int pending();
      return ends_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [LEN_W-1:0] cfg_data_i;

  asm_stream_if #(.payload_t(in_item_t))  text_if ();
  asm_stream_if #(.payload_t(out_item_t)) match_if ();

  approx_substring_matcher_top #(
    .MAX_PATTERN(MAX_PAT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (text_if),
    .out_o      (match_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  match_predictor sb = new();

  logic [SYM_W-1:0] pat_img [MAX_PAT];
  bit loaded [MAX_PAT];
  bit calm = 1'b0;
  bit small_alpha = 1'b0;
  bit long_hold = 1'b0;
  logic [SYM_W-1:0] alpha_base = '0;
  int unsigned accepted_cnt = 0;
  int unsigned cycle_cnt = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SYM_W-1:0] rand_sym();
    if (small_alpha) return alpha_base + SYM_W'($urandom_range(0, 3));
    return SYM_W'($urandom_range(0, 255));
  endfunction

  // result side: random back-pressure, one long hold on request
  initial begin
    int hold;
    hold = 0;
    match_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (match_if.valid && match_if.ready) sb.check_end(match_if.data);
      if (long_hold) begin
        long_hold = 1'b0;
        match_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (hold > 0) begin
        hold--;
        match_if.ready <= 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        match_if.ready <= 1'b1;
      end else begin
        match_if.ready <= 1'b0;
        hold = pause_len();
      end
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    text_if.valid <= 1'b1;
    text_if.data <= it;
    do @(posedge clk_i); while (!text_if.ready);
    sb.note_item(it);
    if (it.kind != KIND_UNUSED) accepted_cnt++;
    gap = calm ? 0 : pause_len();
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_load(input int idx, input logic [SYM_W-1:0] sym);
    in_item_t it;
    it.kind = KIND_LOAD;
    it.symbol = sym;
    it.pattern_index = IDX_W'(idx);
    send_item(it);
    pat_img[idx] = sym;
    loaded[idx] = 1'b1;
  endtask

  task automatic send_text(input logic [SYM_W-1:0] sym);
    in_item_t it;
    it.kind = KIND_TEXT;
    it.symbol = sym;
    it.pattern_index = IDX_W'($urandom_range(0, 63));
    send_item(it);
  endtask

  task automatic send_other(input logic [KIND_W-1:0] kind);
    in_item_t it;
    it.kind = kind;
    it.symbol = SYM_W'($urandom_range(0, 255));
    it.pattern_index = IDX_W'($urandom_range(0, 63));
    send_item(it);
  endtask

  // a copy of the pattern with a few substitutions, drops and insertions
  task automatic send_copy(input int k);
    int edits, len, r;
    len = sb.eff_len();
    edits = (k < 3) ? k + 1 : 3;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (edits > 0 && r < 6) begin
        edits--;
        send_text(rand_sym());
      end else if (edits > 0 && r < 10) begin
        edits--;
      end else if (edits > 0 && r < 14) begin
        edits--;
        send_text(rand_sym());
        send_text(pat_img[i]);
      end else begin
        send_text(pat_img[i]);
      end
    end
  endtask

  task automatic settle();
    text_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [K_W-1:0] k, input logic [LEN_W-1:0] plen);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_THRESHOLD;
    cfg_data_i <= LEN_W'(k);
    @(posedge clk_i);
    sb.write_reg(CFG_THRESHOLD, LEN_W'(k));
    cfg_idx_i <= CFG_LENGTH;
    cfg_data_i <= plen;
    @(posedge clk_i);
    sb.write_reg(CFG_LENGTH, plen);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int k, input int plen, input bit fresh_scan,
                           input int budget, input bit squeeze);
    int len, pick, start;
    bit reload;
    settle();
    write_regs(K_W'(k), LEN_W'(plen));
    calm = ($urandom_range(0, 3) == 0);
    small_alpha = ($urandom_range(0, 2) != 0);
    alpha_base = SYM_W'($urandom_range(0, 252));
    reload = 1'($urandom_range(0, 1));
    len = sb.eff_len();
    for (int i = 0; i < len; i++) begin
      if (!loaded[i] || reload) send_load(i, rand_sym());
    end
    if (fresh_scan) send_other(KIND_RESTART);
    if (squeeze) long_hold = 1'b1;
    start = accepted_cnt;
    while (accepted_cnt - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_copy(k);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) send_text(rand_sym());
      end else if (pick < 91) begin
        send_load($urandom_range(0, 63), rand_sym());
      end else if (pick < 96) begin
        send_other(KIND_RESTART);
      end else begin
        send_other(KIND_UNUSED);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    text_if.valid = 1'b0;
    text_if.data = '0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // exact match, miss, cut-off down to row zero, unused kind
    settle();
    write_regs(K_W'(0), LEN_W'(4));
    send_load(0, 8'h00);
    send_load(1, 8'hFF);
    send_load(2, 8'h55);
    send_load(3, 8'hAA);
    send_load(63, 8'hFF);
    send_load(42, 8'h12);
    send_load(21, 8'hED);
    send_other(KIND_RESTART);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(8'h55);
    send_text(8'hAA);
    send_text(8'h01);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(8'h55);
    send_text(8'hAA);
    send_other(KIND_UNUSED);
    send_other(KIND_RESTART);
    send_text(8'hAA);

    // threshold raised to the top without a restart: the active rows regrow, no match yet
    settle();
    write_regs(K_W'(63), LEN_W'(4));
    send_text(8'h33);
    send_text(8'h00);
    send_text(8'hC3);

    run_phase(2, 4, 1'b1, 30, 1'b0);
    run_phase(63, 8, 1'b1, 30, 1'b1);
    run_phase(0, 1, 1'b1, 20, 1'b0);
    run_phase(1, 0, 1'b1, 20, 1'b0);
    run_phase(5, 127, 1'b1, 40, 1'b0);
    run_phase(0, 64, 1'b1, 40, 1'b0);
    run_phase(3, 10, 1'b0, 30, 1'b0);
    run_phase(1, 6, 1'b1, 30, 1'b0);
    run_phase(63, 64, 1'b1, 20, 1'b0);
    repeat (4) begin
      run_phase(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4),
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12),
                $urandom_range(0, 4) != 0, 25, 1'b0);
    end

    settle();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/asm_pkg.sv
rtl/asm_stream_if.sv
rtl/asm_cell.sv
rtl/approx_substring_matcher_top.sv
rtl/asm_checker.sv
bench/tb_approx_substring_matcher_top.sv
